// ===== hw/rtl/rhcts_pkg.sv =====
`default_nettype none

package rhcts_pkg;

   // channel limits of an RGB565 pixel
   localparam logic [4:0] RED_TOP   = 5'd31;
   localparam logic [5:0] GREEN_TOP = 6'd63;
   localparam logic [4:0] BLUE_TOP  = 5'd31;

   // divisor of the level scaling
   localparam logic [5:0] LEVEL_FULL = 6'd63;

   // configuration register indexes (byte address bit 2)
   localparam logic REG_FOREGROUND = 1'b0;
   localparam logic REG_BACKGROUND = 1'b1;

   // reset value of the shade level
   localparam logic [5:0] BACKGROUND_RESET = 6'd63;

   // operations that go through the shared scale unit, in issue order
   typedef enum logic [2:0] {
      OP_TINT_R  = 3'd0,
      OP_TINT_G  = 3'd1,
      OP_TINT_B  = 3'd2,
      OP_SHADE_R = 3'd3,
      OP_SHADE_G = 3'd4,
      OP_SHADE_B = 3'd5
   } op_tag_type;

   // one request to the scale unit: addend + floor(a * b / 63)
   typedef struct packed {
      logic       valid;
      op_tag_type tag;
      logic [5:0] a;
      logic [5:0] b;
      logic [5:0] addend;
   } op_type;

   // one answer from the scale unit
   typedef struct packed {
      logic       valid;
      op_tag_type tag;
      logic [5:0] value;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb565_hue_cycle_tint_shade.sv =====
`default_nettype none

// Channel   Ports                        Handshake
// request   req_reverse                  req_valid / req_ready
// response  rsp_hue_word, rsp_foreground_word, rsp_background_word
//                                        rsp_valid / rsp_ready
// config    paddr, pwdata, prdata        psel / penable / pwrite / pready
//
// The hue steps at the accepting edge; six scale operations (three tints,
// three shades) then issue one per cycle into the shared two-stage unit, and
// the result shows once the last shade has left the unit. It holds until
// rsp_ready; req_ready returns the cycle after it is taken, so a new item is
// accepted only after the last one has been taken. Synchronous active-high
// reset restores pure red, foreground level 0 and background level 63.

module rgb565_hue_cycle_tint_shade (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_reverse,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [15:0] rsp_hue_word,
   output logic      [15:0] rsp_foreground_word,
   output logic      [15:0] rsp_background_word,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   logic [5:0] fg_level_ff, fg_level_in;
   logic [5:0] bg_level_ff, bg_level_in;

   logic [4:0] hue_r_ff, hue_r_in;
   logic [5:0] hue_g_ff, hue_g_in;
   logic [4:0] hue_b_ff, hue_b_in;
   logic [4:0] step_r;
   logic [5:0] step_g;
   logic [4:0] step_b;

   logic [5:0] fr_ff, fg_ff, fb_ff;
   logic [5:0] br_ff, bg_ff, bb_ff;

   logic req_fire, cfg_write;

   rhcts_pkg::op_type     op;
   rhcts_pkg::result_type res;

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      fg_level_in = fg_level_ff;
      bg_level_in = bg_level_ff;
      if (cfg_write) begin
         case (paddr[2])
            rhcts_pkg::REG_FOREGROUND: fg_level_in = pwdata[5:0];
            rhcts_pkg::REG_BACKGROUND: bg_level_in = pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         rhcts_pkg::REG_FOREGROUND: prdata = {26'd0, fg_level_ff};
         rhcts_pkg::REG_BACKGROUND: prdata = {26'd0, bg_level_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_level_ff <= 6'd0;
         bg_level_ff <= rhcts_pkg::BACKGROUND_RESET;
      end else begin
         fg_level_ff <= fg_level_in;
         bg_level_ff <= bg_level_in;
      end
   end

   // hue step on the accepting edge
   rhcts_hue_step u_step (
      .reverse    (req_reverse),
      .red        (hue_r_ff),
      .green      (hue_g_ff),
      .blue       (hue_b_ff),
      .red_next   (step_r),
      .green_next (step_g),
      .blue_next  (step_b)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign hue_r_in = req_fire ? step_r : hue_r_ff;
   assign hue_g_in = req_fire ? step_g : hue_g_ff;
   assign hue_b_in = req_fire ? step_b : hue_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_r_ff <= rhcts_pkg::RED_TOP;
         hue_g_ff <= 6'd0;
         hue_b_ff <= 5'd0;
      end else begin
         hue_r_ff <= hue_r_in;
         hue_g_ff <= hue_g_in;
         hue_b_ff <= hue_b_in;
      end
   end

   // pick the operands of the operation being issued
   always_comb begin
      op.valid  = (state_ff == ST_ISSUE);
      op.tag    = rhcts_pkg::op_tag_type'(cnt_ff);
      op.a      = 6'd0;
      op.b      = fg_level_ff;
      op.addend = 6'd0;
      case (rhcts_pkg::op_tag_type'(cnt_ff))
         rhcts_pkg::OP_TINT_R: begin
            op.a      = {1'b0, rhcts_pkg::RED_TOP - hue_r_ff};
            op.addend = {1'b0, hue_r_ff};
         end
         rhcts_pkg::OP_TINT_G: begin
            op.a      = rhcts_pkg::GREEN_TOP - hue_g_ff;
            op.addend = hue_g_ff;
         end
         rhcts_pkg::OP_TINT_B: begin
            op.a      = {1'b0, rhcts_pkg::BLUE_TOP - hue_b_ff};
            op.addend = {1'b0, hue_b_ff};
         end
         rhcts_pkg::OP_SHADE_R: begin
            op.a = fr_ff;
            op.b = bg_level_ff;
         end
         rhcts_pkg::OP_SHADE_G: begin
            op.a = fg_ff;
            op.b = bg_level_ff;
         end
         rhcts_pkg::OP_SHADE_B: begin
            op.a = fb_ff;
            op.b = bg_level_ff;
         end
         default: ;
      endcase
   end

   rhcts_scale_unit u_scale (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   // collect results by tag
   always_ff @(posedge clock) begin
      if (res.valid) begin
         case (res.tag)
            rhcts_pkg::OP_TINT_R:  fr_ff <= res.value;
            rhcts_pkg::OP_TINT_G:  fg_ff <= res.value;
            rhcts_pkg::OP_TINT_B:  fb_ff <= res.value;
            rhcts_pkg::OP_SHADE_R: br_ff <= res.value;
            rhcts_pkg::OP_SHADE_G: bg_ff <= res.value;
            rhcts_pkg::OP_SHADE_B: bb_ff <= res.value;
            default: ;
         endcase
      end
   end

   // sequencer: issue six operations, wait for the last, present the item
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = 3'd0;
            if (req_fire) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cnt_in = cnt_ff + 3'd1;
            if (rhcts_pkg::op_tag_type'(cnt_ff) == rhcts_pkg::OP_SHADE_B) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (res.valid && (res.tag == rhcts_pkg::OP_SHADE_B)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // pack the held colors
   assign rsp_valid           = (state_ff == ST_OUT);
   assign rsp_hue_word        = {hue_r_ff, hue_g_ff, hue_b_ff};
   assign rsp_foreground_word = {fr_ff[4:0], fg_ff, fb_ff[4:0]};
   assign rsp_background_word = {br_ff[4:0], bg_ff, bb_ff[4:0]};

`ifndef SYNTH
   // an accepted item blocks the request side on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side still ready after an accepted item");

   // the shared unit answers only while an item is in work
   a_result_in_work: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> !req_ready && !rsp_valid)
      else $error("scale result outside an item");

   // a result is never shown while a new item can enter
   a_out_excl_ready: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("response valid while request side ready");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rhcts_hue_step.sv =====
`default_nettype none

module rhcts_hue_step (
   input  wire logic       reverse,
   input  wire logic [4:0] red,
   input  wire logic [5:0] green,
   input  wire logic [4:0] blue,
   output logic      [4:0] red_next,
   output logic      [5:0] green_next,
   output logic      [4:0] blue_next
);

   logic r_max, g_max, b_max, r_min, g_min, b_min;
   logic r_up, r_dn, g_up, g_dn, b_up, b_dn;

   // flags from the hue before the step
   assign r_max = (red == rhcts_pkg::RED_TOP);
   assign g_max = (green == rhcts_pkg::GREEN_TOP);
   assign b_max = (blue == rhcts_pkg::BLUE_TOP);
   assign r_min = (red == 5'd0);
   assign g_min = (green == 6'd0);
   assign b_min = (blue == 5'd0);

   // swap up and down conditions for the opposite order
   always_comb begin
      if (reverse) begin
         r_up = g_max && b_min;  r_dn = b_max && g_min;
         g_up = b_max && r_min;  g_dn = r_max && b_min;
         b_up = r_max && g_min;  b_dn = g_max && r_min;
      end else begin
         r_up = b_max && g_min;  r_dn = g_max && b_min;
         g_up = r_max && b_min;  g_dn = b_max && r_min;
         b_up = g_max && r_min;  b_dn = r_max && g_min;
      end
   end

   // move each channel one unit, never past its limits
   always_comb begin
      red_next = red;
      if (r_up && !r_max) begin
         red_next = red + 5'd1;
      end else if (r_dn && !r_min) begin
         red_next = red - 5'd1;
      end

      green_next = green;
      if (g_up && !g_max) begin
         green_next = green + 6'd1;
      end else if (g_dn && !g_min) begin
         green_next = green - 6'd1;
      end

      blue_next = blue;
      if (b_up && !b_max) begin
         blue_next = blue + 5'd1;
      end else if (b_dn && !b_min) begin
         blue_next = blue - 5'd1;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rhcts_scale_unit.sv =====
`default_nettype none

module rhcts_scale_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rhcts_pkg::op_type    op,
   output rhcts_pkg::result_type     res
);

   logic                  valid_ff, valid_in;
   rhcts_pkg::op_tag_type tag_ff;
   logic [11:0]           prod_ff, prod_in;
   logic [5:0]            addend_ff;

   rhcts_pkg::result_type res_ff, res_in;

   logic [5:0] quot_low;
   logic [6:0] rem;
   logic [5:0] quot;

   // stage one: 6 x 6 product
   assign valid_in = op.valid;
   assign prod_in  = 12'({6'd0, op.a} * {6'd0, op.b});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tag_ff    <= op.tag;
      prod_ff   <= prod_in;
      addend_ff <= op.addend;
   end

   // stage two: divide by 63 as p/64 plus one correction
   // remainder of the estimate stays below 2 * 63, so one compare does
   assign quot_low = prod_ff[11:6];
   assign rem      = {1'b0, prod_ff[5:0]} + {1'b0, quot_low};
   assign quot     = quot_low + {5'd0, (rem >= {1'b0, rhcts_pkg::LEVEL_FULL})};

   always_comb begin
      res_in.valid = valid_ff;
      res_in.tag   = tag_ff;
      res_in.value = addend_ff + quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= res_in.valid;
      end
      res_ff.tag   <= res_in.tag;
      res_ff.value <= res_in.value;
   end

   assign res = res_ff;

endmodule

`default_nettype wire
